// ===== sv/pddtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pddtm_pkg: shared types and constants of the decay-time matcher
// Transaction payload structs, sequencer states, particle codes and the
// configuration register map.
// ----------------------------------------------------------------------------
package pddtm_pkg;

    // Default sizes of the id and time tables.
    localparam int DEF_TABLE_DEPTH = 512;
    localparam int DEF_TIME_WIDTH  = 32;

    // Fixed field widths.
    localparam int ID_W       = 24;
    localparam int CODE_W     = 32;
    localparam int CNTR_W     = 8;
    localparam int IN_TIME_W  = 32;
    localparam int OUT_TIME_W = 33;
    localparam int SLOT_W     = 9;

    // Particle codes of interest, both charges.
    localparam logic signed [CODE_W-1:0] CODE_MUON_POS     = 32'sd13;
    localparam logic signed [CODE_W-1:0] CODE_MUON_NEG     = -32'sd13;
    localparam logic signed [CODE_W-1:0] CODE_ELECTRON_POS = 32'sd11;
    localparam logic signed [CODE_W-1:0] CODE_ELECTRON_NEG = -32'sd11;

    // Configuration register map (word index) and reset values.
    localparam logic CFG_MUON_COUNTER     = 1'b0;
    localparam logic CFG_ELECTRON_COUNTER = 1'b1;
    localparam logic [CNTR_W-1:0] RST_MUON_COUNTER     = 8'd1;
    localparam logic [CNTR_W-1:0] RST_ELECTRON_COUNTER = 8'd3;

    // One detector hit.
    typedef struct packed {
        logic                     event_start;
        logic signed [CODE_W-1:0] particle_code;
        logic [CNTR_W-1:0]        detector_counter;
        logic [ID_W-1:0]          track_id;
        logic [ID_W-1:0]          parent_track_id;
        logic                     entry_step;
        logic [IN_TIME_W-1:0]     hit_time;
    } t_hit;

    // One matched decay.
    typedef struct packed {
        logic signed [OUT_TIME_W-1:0] decay_time;
        logic [SLOT_W-1:0]            parent_slot;
    } t_result;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MU_SCAN,
        S_EL_SCAN,
        S_P_SCAN,
        S_T_READ
    } t_state;

endpackage

// ===== sv/pddtm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pddtm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pddtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/parent_daughter_decay_time_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parent_daughter_decay_time_matcher: muon / decay-electron time matcher
// Records first-step muons and electrons per event and reports the time from
// a recorded muon to the arrival of its daughter electron.
// ----------------------------------------------------------------------------
// Usage:
// Hits enter on the input channel (i_in_valid / o_in_stall / i_in_data) and
// matched decays leave on the output channel (o_out_valid / i_out_stall /
// o_out_data). The block takes a hit only while its sequencer is idle.
// A muon hit scans the muon id table once; an electron hit scans the
// electron id table and, if the electron is new, then the muon id table
// for its parent. One compare unit serves every scan at one table entry
// per cycle. On a match the sequencer reads the parent time in S_T_READ
// and loads the result into an output register; if the receiver still
// stalls an older result, the sequencer waits there.
// A new hit can be accepted while a result waits in the output register.
// Event start empties both tables at once through their fill counts.
// Reset clears the fill counts, the output valid and sets the counter
// registers to 1 (muon) and 3 (electron); the tables are not cleared.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module parent_daughter_decay_time_matcher import pddtm_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Hit input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_hit        i_in_data,
    // Result output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_data,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int TWE = (TIME_WIDTH < IN_TIME_W) ? TIME_WIDTH : IN_TIME_W;

    t_state              r_state, n_state;
    logic [CNTR_W-1:0]   r_mu_cfg, r_el_cfg;
    logic [CW-1:0]       r_mu_count, n_mu_count;
    logic [CW-1:0]       r_el_count, n_el_count;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic [IW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_cmp_valid, n_cmp_valid;
    logic [ID_W-1:0]     r_key, n_key;
    logic [ID_W-1:0]     r_parent, n_parent;
    logic [TWE-1:0]      r_time, n_time;
    logic                r_out_valid, n_out_valid;
    t_result             r_out_data, n_out_data;

    logic                w_accept;
    logic                w_is_mu, w_is_el;
    logic [ID_W-1:0]     w_mu_id_rd, w_el_id_rd, w_cmp_data;
    logic [TWE-1:0]      w_mu_time_rd;
    logic [CW-1:0]       w_scan_count;
    logic                w_hit, w_more;
    logic                w_mu_we, w_el_we;
    logic [OUT_TIME_W-1:0] w_diff;
    logic [31:0]         w_slot_ext;
    logic                w_cfg_wr;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_cfg <= RST_MUON_COUNTER;
            r_el_cfg <= RST_ELECTRON_COUNTER;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                CFG_MUON_COUNTER:     r_mu_cfg <= pwdata[CNTR_W-1:0];
                CFG_ELECTRON_COUNTER: r_el_cfg <= pwdata[CNTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_MUON_COUNTER:     prdata = 32'(r_mu_cfg);
            CFG_ELECTRON_COUNTER: prdata = 32'(r_el_cfg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Table memories
    // ------------------------------------------------------------------
    pddtm_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_mu_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_mu_we),
        .i_waddr (r_mu_count[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (w_mu_id_rd)
    );

    pddtm_ram #(.WIDTH(TWE), .DEPTH(TABLE_DEPTH)) u_mu_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_mu_we),
        .i_waddr (r_mu_count[IW-1:0]),
        .i_wdata (r_time),
        .i_raddr (r_cmp_idx),
        .o_rdata (w_mu_time_rd)
    );

    pddtm_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_el_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_el_we),
        .i_waddr (r_el_count[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (w_el_id_rd)
    );

    // ------------------------------------------------------------------
    // Hit classification and the shared id comparator
    // ------------------------------------------------------------------
    assign w_accept = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_is_mu = i_in_data.entry_step
                   && (i_in_data.particle_code == CODE_MUON_POS
                       || i_in_data.particle_code == CODE_MUON_NEG)
                   && (i_in_data.detector_counter == r_mu_cfg);
    assign w_is_el = i_in_data.entry_step
                   && (i_in_data.particle_code == CODE_ELECTRON_POS
                       || i_in_data.particle_code == CODE_ELECTRON_NEG)
                   && (i_in_data.detector_counter == r_el_cfg);

    assign w_cmp_data   = (r_state == S_EL_SCAN) ? w_el_id_rd : w_mu_id_rd;
    assign w_scan_count = (r_state == S_EL_SCAN) ? r_el_count : r_mu_count;
    assign w_hit        = r_cmp_valid && (w_cmp_data == r_key);
    assign w_more       = (r_rd_idx < w_scan_count);

    // Electron time minus muon time, both zero-extended.
    assign w_diff     = OUT_TIME_W'(r_time) - OUT_TIME_W'(w_mu_time_rd);
    assign w_slot_ext = 32'(r_cmp_idx);

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_mu_count  = r_mu_count;
        n_el_count  = r_el_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_key       = r_key;
        n_parent    = r_parent;
        n_time      = r_time;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_data  = r_out_data;
        w_mu_we     = 1'b0;
        w_el_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key       = i_in_data.track_id;
                    n_parent    = i_in_data.parent_track_id;
                    n_time      = i_in_data.hit_time[TWE-1:0];
                    n_rd_idx    = '0;
                    n_cmp_valid = 1'b0;
                    if (i_in_data.event_start) begin
                        n_mu_count = '0;
                        n_el_count = '0;
                    end
                    if (w_is_mu) begin
                        n_state = S_MU_SCAN;
                    end else if (w_is_el) begin
                        n_state = S_EL_SCAN;
                    end
                end
            end

            S_MU_SCAN, S_EL_SCAN, S_P_SCAN: begin
                // Issue the next read and compare the previous one.
                n_cmp_valid = w_more;
                if (w_more) begin
                    n_cmp_idx = r_rd_idx[IW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                end
                if (w_hit) begin
                    n_cmp_idx = r_cmp_idx;
                    if (r_state == S_P_SCAN) begin
                        n_state = S_T_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!r_cmp_valid && !w_more) begin
                    // Scan ended without a match.
                    case (r_state)
                        S_MU_SCAN: begin
                            if (r_mu_count < CW'(TABLE_DEPTH)) begin
                                w_mu_we    = 1'b1;
                                n_mu_count = r_mu_count + CW'(1);
                            end
                            n_state = S_IDLE;
                        end
                        S_EL_SCAN: begin
                            if (r_el_count < CW'(TABLE_DEPTH)) begin
                                w_el_we     = 1'b1;
                                n_el_count  = r_el_count + CW'(1);
                                n_key       = r_parent;
                                n_rd_idx    = '0;
                                n_cmp_valid = 1'b0;
                                n_state     = S_P_SCAN;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_T_READ: begin
                // Parent time is on the read port; wait for a free output.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_data.decay_time  = $signed(w_diff);
                    n_out_data.parent_slot = w_slot_ext[SLOT_W-1:0];
                    n_state                = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_count  <= '0;
            r_el_count  <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mu_count  <= n_mu_count;
            r_el_count  <= n_el_count;
            r_rd_idx    <= n_rd_idx;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_key      <= n_key;
        r_parent   <= n_parent;
        r_time     <= n_time;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mu_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mu_count <= CW'(TABLE_DEPTH))
        else $error("muon fill count exceeds table depth");

    a_el_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_el_count <= CW'(TABLE_DEPTH))
        else $error("electron fill count exceeds table depth");

    a_parent_scan_has_el: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_SCAN) |-> (r_el_count != '0))
        else $error("parent scan without a recorded electron");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_READ && !(r_out_valid && i_out_stall)) |=> o_out_valid)
        else $error("matched decay not loaded into the output register");

    a_scan_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MU_SCAN || r_state == S_EL_SCAN || r_state == S_P_SCAN)
        |-> (r_rd_idx <= w_scan_count))
        else $error("scan read index ran past the fill count");

endmodule
